[src/millisecond_timer_bank_defines.svh]
// Assertion macros for the port checker file of the timer bank.
`ifndef MILLISECOND_TIMER_BANK_DEFINES_SVH
`define MILLISECOND_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define MTB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define MTB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[src/mtb_pkg.sv]
// Types, constants and codes shared by the millisecond timer bank.
package mtb_pkg;

  localparam int CH_W  = 4;
  localparam int DLY_W = 32;
  localparam int MS_W  = 31;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_PERIODIC_DEF = 16;
  localparam int NUM_ONESHOT_DEF  = 16;

  localparam logic [DLY_W-1:0] WRAP_LIMIT = 32'h7FFF_FFFF;
  localparam logic [MS_W-1:0]  MS_MAX     = 31'h7FFF_FFFF;

  localparam logic [CFG_W-1:0] TICKS_PER_TENTH_RST   = 8'd100;
  localparam logic [CFG_W-1:0] TENTHS_PER_SECOND_RST = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_TENTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TENTHS_PER_SECOND = 1'b1;

  typedef enum logic [2:0] {
    FN_TICK      = 3'd0,
    FN_START     = 3'd1,
    FN_POLL      = 3'd2,
    FN_CLEAR     = 3'd3,
    FN_CLEAR_ALL = 3'd4,
    FN_ONESHOT   = 3'd5,
    FN_RD_TENTH  = 3'd6,
    FN_RD_SECOND = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_WRAP_RD,
    S_WRAP_WR
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [CH_W-1:0]   channel;
    logic [DLY_W-1:0]  delay_ms;
  } in_t;

  typedef struct packed {
    logic              fired;
    logic [MS_W-1:0]   ms_now;
  } out_t;

  typedef struct packed {
    logic              active;
    logic [DLY_W-1:0]  period;
    logic [DLY_W-1:0]  deadline;
  } chan_ent_t;

  typedef struct packed {
    logic tick;
    logic clr_tenth;
    logic clr_second;
  } presc_ctrl_t;

  typedef struct packed {
    logic tenth;
    logic second;
  } presc_flags_t;

endpackage

[src/mtb_ram.sv]
// Single-port-write, single-port-read memory with per-entry valid bits (invalid reads as zero).
module mtb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr_all,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] mem_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clr_all) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mem_q  <= mem[rd_addr];
    rd_vld <= valid[rd_addr];
  end

  assign rd_data = rd_vld ? mem_q : '0;

endmodule

[src/mtb_prescale.sv]
// Tick prescaler: tenth-second and second dividers, their flags and config registers.
module mtb_prescale
  import mtb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  presc_ctrl_t          ctrl,
  output presc_flags_t         flags
);

  logic [CFG_W-1:0] ticks_per_tenth;
  logic [CFG_W-1:0] tenths_per_second;
  logic [CFG_W-1:0] tenth_div;
  logic [CFG_W-1:0] second_div;
  logic             tenth_flag;
  logic             second_flag;
  logic [CFG_W-1:0] tenth_inc;
  logic [CFG_W-1:0] second_inc;

  assign tenth_inc  = tenth_div + 8'd1;
  assign second_inc = second_div + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_tenth   <= TICKS_PER_TENTH_RST;
      tenths_per_second <= TENTHS_PER_SECOND_RST;
      tenth_div         <= '0;
      second_div        <= '0;
      tenth_flag        <= 1'b0;
      second_flag       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TICKS_PER_TENTH:   ticks_per_tenth   <= cfg_wdata;
          CFG_TENTHS_PER_SECOND: tenths_per_second <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctrl.tick) begin
        if (tenth_inc >= ticks_per_tenth) begin
          tenth_div  <= '0;
          tenth_flag <= 1'b1;
          if (second_inc >= tenths_per_second) begin
            second_div  <= '0;
            second_flag <= 1'b1;
          end else begin
            second_div <= second_inc;
          end
        end else begin
          tenth_div <= tenth_inc;
        end
      end
      // reads clear the flag; never in the same cycle as a tick
      if (ctrl.clr_tenth) begin
        tenth_flag <= 1'b0;
      end
      if (ctrl.clr_second) begin
        second_flag <= 1'b0;
      end
    end
  end

  assign flags = '{tenth: tenth_flag, second: second_flag};

endmodule

[src/millisecond_timer_bank.sv]
// A request is captured into in_q and run in S_EXEC, which loads the output register,
// or S_EMIT does while the output stalls; no request is taken until this one is done
// (memory read, then modify and write back). A tick that wraps the counter then adds
// a deadline sweep: one read and one write per periodic channel in the channel memory.
// Reset (rst, synchronous) clears counter, dividers, flags and all entry valid bits,
// so every channel and one-shot entry reads as zero at once; there is no clearing pass.
module millisecond_timer_bank
  import mtb_pkg::*;
#(
  parameter int NUM_PERIODIC = NUM_PERIODIC_DEF,
  parameter int NUM_ONESHOT  = NUM_ONESHOT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int PAW = (NUM_PERIODIC > 1) ? $clog2(NUM_PERIODIC) : 1;
  localparam int OAW = (NUM_ONESHOT > 1) ? $clog2(NUM_ONESHOT) : 1;
  localparam int PDW = $bits(chan_ent_t);
  localparam logic [PAW-1:0] P_LAST = PAW'(NUM_PERIODIC - 1);

  state_e            state, state_next;
  in_t               in_q;
  logic [MS_W-1:0]   ms, ms_next;
  logic              wrap_pend;
  logic [PAW-1:0]    widx;
  out_t              res_q, res_c;
  logic              fired_c;
  logic              wrap_c;
  logic              load_out;

  presc_ctrl_t       pctl;
  presc_flags_t      pflags;

  logic              pclr;
  logic [PAW-1:0]    prd_addr, pwr_addr, p_ch_addr;
  logic              pwr_en;
  chan_ent_t         pwr_data, pr;
  logic [PDW-1:0]    prd_data;

  logic [OAW-1:0]    ord_addr, o_ch_addr;
  logic              owr_en;
  logic [DLY_W-1:0]  owr_data, od;

  logic              ch_p_ok, ch_o_ok;
  logic [DLY_W-1:0]  ms_ext, dly_sum, per_sum, adj;
  logic [MS_W-1:0]   ms_plus;

  assign in_stall  = (state != S_IDLE);
  assign p_ch_addr = PAW'(in_q.channel);
  assign o_ch_addr = OAW'(in_q.channel);
  assign prd_addr  = (state == S_WRAP_RD) ? widx : PAW'(in_data.channel);
  assign ord_addr  = OAW'(in_data.channel);
  assign pr        = chan_ent_t'(prd_data);

  assign ch_p_ok = 32'(in_q.channel) < NUM_PERIODIC;
  assign ch_o_ok = 32'(in_q.channel) < NUM_ONESHOT;
  assign ms_ext  = {1'b0, ms};
  assign dly_sum = ms_ext + in_q.delay_ms;
  assign per_sum = ms_ext + pr.period;
  assign ms_plus = ms + 31'd1;
  assign adj     = (pr.deadline > WRAP_LIMIT) ? (pr.deadline - WRAP_LIMIT) : '0;

  mtb_ram #(
    .DEPTH (NUM_PERIODIC),
    .WIDTH (PDW)
  ) u_pram (
    .clk     (clk),
    .rst     (rst),
    .clr_all (pclr),
    .rd_addr (prd_addr),
    .wr_en   (pwr_en),
    .wr_addr (pwr_addr),
    .wr_data (pwr_data),
    .rd_data (prd_data)
  );

  mtb_ram #(
    .DEPTH (NUM_ONESHOT),
    .WIDTH (DLY_W)
  ) u_oram (
    .clk     (clk),
    .rst     (rst),
    .clr_all (1'b0),
    .rd_addr (ord_addr),
    .wr_en   (owr_en),
    .wr_addr (o_ch_addr),
    .wr_data (owr_data),
    .rd_data (od)
  );

  mtb_prescale u_presc (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctrl      (pctl),
    .flags     (pflags)
  );

  always_comb begin
    state_next = state;
    pctl       = '0;
    pclr       = 1'b0;
    pwr_en     = 1'b0;
    pwr_addr   = p_ch_addr;
    pwr_data   = pr;
    owr_en     = 1'b0;
    owr_data   = '0;
    ms_next    = ms;
    fired_c    = 1'b0;
    wrap_c     = 1'b0;
    load_out   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (in_q.func)
          FN_TICK: begin
            pctl.tick = 1'b1;
            if (ms_plus == MS_MAX) begin
              ms_next = '0;
              wrap_c  = 1'b1;
            end else begin
              ms_next = ms_plus;
            end
          end
          FN_START: begin
            pwr_en   = ch_p_ok;
            pwr_data = '{active: 1'b1, period: in_q.delay_ms, deadline: dly_sum};
          end
          FN_POLL: begin
            if (ch_p_ok && pr.active && (ms_ext >= pr.deadline)) begin
              pwr_en            = 1'b1;
              pwr_data.deadline = per_sum;
              fired_c           = 1'b1;
            end
          end
          FN_CLEAR: begin
            pwr_en   = ch_p_ok;
            pwr_data = '0;
          end
          FN_CLEAR_ALL: begin
            pclr    = 1'b1;
            ms_next = '0;
          end
          FN_ONESHOT: begin
            if (ch_o_ok) begin
              if (od == '0) begin
                owr_en   = 1'b1;
                owr_data = dly_sum;
              end else if (ms_ext >= od) begin
                owr_en   = 1'b1;
                owr_data = '0;
                fired_c  = 1'b1;
              end
            end
          end
          FN_RD_TENTH: begin
            fired_c        = pflags.tenth;
            pctl.clr_tenth = 1'b1;
          end
          FN_RD_SECOND: begin
            fired_c         = pflags.second;
            pctl.clr_second = 1'b1;
          end
          default: ;
        endcase
        load_out = !out_valid || !out_stall;
        if (!load_out) begin
          state_next = S_EMIT;
        end else if (wrap_c) begin
          state_next = S_WRAP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        load_out = !out_valid || !out_stall;
        if (load_out) begin
          state_next = wrap_pend ? S_WRAP_RD : S_IDLE;
        end
      end
      S_WRAP_RD: begin
        state_next = S_WRAP_WR;
      end
      S_WRAP_WR: begin
        pwr_en            = 1'b1;
        pwr_addr          = widx;
        pwr_data.deadline = adj;
        state_next        = (widx == P_LAST) ? S_IDLE : S_WRAP_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res_c = '{fired: fired_c, ms_now: ms_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms        <= '0;
      wrap_pend <= 1'b0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      ms <= ms_next;
      if (state == S_EXEC) begin
        wrap_pend <= wrap_c;
        widx      <= '0;
      end else if (state == S_WRAP_WR) begin
        widx <= widx + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      in_q <= in_data;
    end
    if (state == S_EXEC) begin
      res_q <= res_c;
    end
    if (load_out) begin
      out_data <= (state == S_EXEC) ? res_c : res_q;
    end
  end

endmodule

[src/mtb_checker.sv]
// Port-level checks for the millisecond timer bank, bound to the top level.
`include "millisecond_timer_bank_defines.svh"

module mtb_port_checks
  import mtb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `MTB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `MTB_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
  `MTB_ASSERT_IMPL(a_ms_below_wrap, out_valid, out_data.ms_now != MS_MAX)

endmodule

bind millisecond_timer_bank mtb_port_checks u_mtb_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/mtb_checker.sv]
// Watches the timer bank's channels, predicts every reply and compares it.
module mtb_checker
  import mtb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam int NP = NUM_PERIODIC_DEF;
  localparam int NO = NUM_ONESHOT_DEF;

  logic [CFG_W-1:0] ticks_per_tenth, tenths_per_second;
  logic [DLY_W-1:0] ms;
  logic [7:0]       tenth_div, second_div;
  logic             tenth_flag, second_flag;
  logic             chan_on    [NP];
  logic [DLY_W-1:0] chan_period[NP];
  logic [DLY_W-1:0] chan_due   [NP];
  logic [DLY_W-1:0] shot_due   [NO];

  out_t replies_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic clear_timer_state();
    ticks_per_tenth   = TICKS_PER_TENTH_RST;
    tenths_per_second = TENTHS_PER_SECOND_RST;
    ms = '0;
    tenth_div = '0;
    second_div = '0;
    tenth_flag = 1'b0;
    second_flag = 1'b0;
    for (int i = 0; i < NP; i++) begin
      chan_on[i] = 1'b0;
      chan_period[i] = '0;
      chan_due[i] = '0;
    end
    for (int i = 0; i < NO; i++) shot_due[i] = '0;
  endtask

  task automatic advance_ms();
    ms = ms + 1;
    // dividers first, counter wrap after
    tenth_div = tenth_div + 8'd1;
    if (tenth_div >= ticks_per_tenth) begin
      tenth_div = '0;
      tenth_flag = 1'b1;
      second_div = second_div + 8'd1;
      if (second_div >= tenths_per_second) begin
        second_div = '0;
        second_flag = 1'b1;
      end
    end
    if (ms >= WRAP_LIMIT) begin
      ms = '0;
      for (int i = 0; i < NP; i++)
        chan_due[i] = (chan_due[i] > WRAP_LIMIT) ? chan_due[i] - WRAP_LIMIT : '0;
    end
  endtask

  task automatic timer_step(input in_t req, output out_t res);
    logic fired;
    int   ch;
    fired = 1'b0;
    ch = int'(req.channel);
    case (req.func)
      FN_TICK: advance_ms();
      FN_START: if (ch < NP) begin
        chan_on[ch] = 1'b1;
        chan_period[ch] = req.delay_ms;
        chan_due[ch] = ms + req.delay_ms;
      end
      FN_POLL: if (ch < NP && chan_on[ch] && ms >= chan_due[ch]) begin
        chan_due[ch] = ms + chan_period[ch];
        fired = 1'b1;
      end
      FN_CLEAR: if (ch < NP) begin
        chan_on[ch] = 1'b0;
        chan_period[ch] = '0;
        chan_due[ch] = '0;
      end
      FN_CLEAR_ALL: begin
        for (int i = 0; i < NP; i++) begin
          chan_on[i] = 1'b0;
          chan_period[i] = '0;
          chan_due[i] = '0;
        end
        ms = '0;
      end
      FN_ONESHOT: if (ch < NO) begin
        // a sum of zero leaves the entry unarmed
        if (shot_due[ch] == '0) begin
          shot_due[ch] = ms + req.delay_ms;
        end else if (ms >= shot_due[ch]) begin
          shot_due[ch] = '0;
          fired = 1'b1;
        end
      end
      FN_RD_TENTH: begin
        fired = tenth_flag;
        tenth_flag = 1'b0;
      end
      default: begin
        fired = second_flag;
        second_flag = 1'b0;
      end
    endcase
    res.fired = fired;
    res.ms_now = ms[MS_W-1:0];
  endtask

  always @(posedge clk) begin
    out_t want, got;
    if (rst) begin
      clear_timer_state();
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICKS_PER_TENTH:   ticks_per_tenth = cfg_wdata;
          CFG_TENTHS_PER_SECOND: tenths_per_second = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        timer_step(in_data, want);
        replies_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("reply with none pending (fired %0b ms %0d)",
                                    got.fired, got.ms_now));
        end else begin
          want = replies_due.pop_front();
          if (got.fired !== want.fired)
            report_mismatch($sformatf("fired %0b, predicted %0b", got.fired, want.fired));
          if (got.ms_now !== want.ms_now)
            report_mismatch($sformatf("ms_now %0d, predicted %0d", got.ms_now, want.ms_now));
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

[bench/tb_millisecond_timer_bank.sv]
// Top of the timer bank bench: clock, reset, request stimulus and verdict.
module tb_millisecond_timer_bank;
  import mtb_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int   fail_count;
  int   pending;
  logic in_take = 1'b0;
  bit   hold_go;

  millisecond_timer_bank dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mtb_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request taken at the last rising edge; read at the falling edge
  always @(posedge clk) in_take <= !rst && in_valid && !in_stall;

  initial begin
    #2_000_000;
    $display("** millisecond_timer_bank: FAILED **");
    $finish;
  end

  // receiver: segments of differing stall density, plus an on-demand long hold-off
  initial begin
    int mode, seg;
    out_stall = 1'b0;
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(20, 80);
        repeat (seg) begin
          case (mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 3) == 0);
            2: out_stall = ($urandom_range(0, 3) != 0);
            default: out_stall = ~out_stall;
          endcase
          @(negedge clk);
          if (hold_go) break;
        end
      end
    end
  end

  task automatic issue(input func_e f, input logic [CH_W-1:0] ch,
                       input logic [DLY_W-1:0] d);
    in_valid = 1'b1;
    in_data.func = f;
    in_data.channel = ch;
    in_data.delay_ms = d;
    @(negedge clk);
    while (!in_take) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold requests until every reply is back, then cover a possible wrap sweep
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * NUM_PERIODIC_DEF + 8) @(negedge clk);
  endtask

  task automatic random_request(output func_e f, output logic [CH_W-1:0] ch,
                                output logic [DLY_W-1:0] d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 34)      f = FN_TICK;
    else if (r < 46) f = FN_START;
    else if (r < 64) f = FN_POLL;
    else if (r < 69) f = FN_CLEAR;
    else if (r < 71) f = FN_CLEAR_ALL;
    else if (r < 88) f = FN_ONESHOT;
    else if (r < 94) f = FN_RD_TENTH;
    else             f = FN_RD_SECOND;
    // a few busy channels so start/poll pairs meet
    ch = ($urandom_range(0, 9) < 7) ? CH_W'($urandom_range(0, 3)) : CH_W'($urandom_range(0, 15));
    r = $urandom_range(0, 19);
    if (r < 12)      d = $urandom_range(0, 25);
    else if (r < 15) d = $urandom;
    else if (r < 17) d = 32'hFFFF_FFFF - $urandom_range(0, 25);
    else if (r < 18) d = 32'h8000_0000 | $urandom;
    else             d = '0;
  endtask

  task automatic run_phase(input int n_items, input bit with_hold);
    int burst_left, gap;
    func_e f;
    logic [CH_W-1:0] ch;
    logic [DLY_W-1:0] d;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      if (with_hold && i == n_items / 2) hold_go = 1'b1;
      random_request(f, ch, d);
      issue(f, ch, d);
      burst_left--;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] tpt[6];
    logic [CFG_W-1:0] tps[6];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_go = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fastest dividers so the flags show up in the directed part
    write_reg(CFG_TICKS_PER_TENTH, 8'd1);
    write_reg(CFG_TENTHS_PER_SECOND, 8'd1);

    issue(FN_RD_TENTH, 4'd0, 32'd0);
    issue(FN_ONESHOT, 4'd0, 32'd0);              // sum of zero: stays unarmed
    issue(FN_START, 4'd15, 32'd2);
    issue(FN_POLL, 4'd15, 32'd0);
    issue(FN_TICK, 4'd0, 32'd0);
    issue(FN_TICK, 4'd9, 32'hFFFF_FFFF);
    issue(FN_POLL, 4'd15, 32'd0);
    issue(FN_RD_TENTH, 4'd0, 32'd0);
    issue(FN_RD_SECOND, 4'd0, 32'd0);
    issue(FN_RD_SECOND, 4'd0, 32'd0);
    issue(FN_ONESHOT, 4'd0, 32'd0);              // arms at the current count
    issue(FN_ONESHOT, 4'd0, 32'd0);
    issue(FN_TICK, 4'd0, 32'd0);
    issue(FN_ONESHOT, 4'd15, 32'hFFFF_FFFD);     // ms + delay wraps to zero
    issue(FN_ONESHOT, 4'd15, 32'hFFFF_FFFF);
    issue(FN_ONESHOT, 4'd15, 32'd0);
    issue(FN_START, 4'd3, 32'hFFFF_FFFF);        // deadline sum wraps below ms
    issue(FN_POLL, 4'd3, 32'd0);
    issue(FN_CLEAR, 4'd3, 32'd0);
    issue(FN_POLL, 4'd3, 32'd0);
    issue(FN_START, 4'd7, 32'd5);
    issue(FN_CLEAR_ALL, 4'd0, 32'd0);
    issue(FN_POLL, 4'd7, 32'd0);
    issue(FN_TICK, 4'd0, 32'd0);
    drain();

    tpt = '{8'd255, 8'd2, 8'd1, 8'd255, CFG_W'($urandom_range(1, 255)),
            CFG_W'($urandom_range(1, 8))};
    tps = '{8'd255, 8'd3, 8'd255, 8'd1, CFG_W'($urandom_range(1, 255)),
            CFG_W'($urandom_range(1, 4))};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_TICKS_PER_TENTH, tpt[p]);
      write_reg(CFG_TENTHS_PER_SECOND, tps[p]);
      run_phase(125, p == 1);
      drain();
    end

    if (fail_count == 0) begin
      $display("** millisecond_timer_bank: PASSED **");
    end else begin
      $display("** millisecond_timer_bank: FAILED **");
    end
    $finish;
  end

endmodule
